// ===== rtl/core/pelt_pi_pkg.sv =====
`timescale 1ns / 1ps

package pelt_pi_pkg;

  // Field and datapath widths.
  localparam int unsigned SAMPLE_W   = 12;
  localparam int unsigned SETP_W     = 13;
  localparam int unsigned ERR_W      = 14;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned PROD_W     = 30;
  localparam int unsigned INTEG_W    = 32;
  localparam int unsigned PI_W       = 34;
  localparam int unsigned PWM_W      = 12;
  localparam int unsigned HOST_W     = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL_DIVISOR = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SETPOINT         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REF_TEMP         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND         = 3'd4;

  // Input request: two ADC samples.
  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_plus;
    logic [SAMPLE_W-1:0] sample_minus;
  } in_t;

  // Result of one control step.
  typedef struct packed {
    logic [PWM_W-1:0]  pwm_width;
    logic              pwm_update;
    logic              relay_on;
    logic              relay_write;
    logic [HOST_W-1:0] host_byte;
  } out_t;

endpackage

// ===== rtl/core/pelt_pi_div.sv =====
`timescale 1ns / 1ps

module pelt_pi_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [pelt_pi_pkg::INTEG_W-1:0]  dividend_i,
  input  logic [pelt_pi_pkg::GAIN_W-1:0]   divisor_i,
  output logic                             done_o,
  output logic [pelt_pi_pkg::INTEG_W-1:0]  quotient_o
);
  import pelt_pi_pkg::*;

  localparam int unsigned CntW = $clog2(INTEG_W);
  localparam logic [CntW-1:0] LastCnt = CntW'(INTEG_W - 1);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [GAIN_W-1:0]   div_q, div_d;
  logic [GAIN_W-1:0]   rem_q, rem_d;
  logic [INTEG_W-1:0]  quo_q, quo_d;
  logic [GAIN_W:0]     shifted;
  logic [GAIN_W:0]     diff;
  logic                fits;

  // One restoring step: bring in the next dividend bit and try the subtract.
  always_comb begin
    shifted = {rem_q, quo_q[INTEG_W-1]};
    diff    = shifted - {1'b0, div_q};
    fits    = shifted >= {1'b0, div_q};
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    div_d  = div_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      div_d  = divisor_i;
      rem_d  = '0;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = fits ? diff[GAIN_W-1:0] : shifted[GAIN_W-1:0];
      quo_d = {quo_q[INTEG_W-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LastCnt) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q <= div_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== rtl/core/peltier_pi_with_direction_relay_core.sv =====
`timescale 1ns / 1ps

// PI temperature controller for a Peltier element with a heat/cool relay.
// Each request carries two ADC samples; their difference is the temperature.
// The block returns one result per request: the new PWM width (clamped to
// 1..PWM_MAX and reported in 12 bits, or zero when no direction is chosen),
// the relay state and a write strobe, and a scaled host byte. On the way
// from acceptance to the result register, a 32-step restoring divider forms
// integral/integral_divisor at one bit per cycle, with a shift-add multiplier
// for the proportional term running alongside; the sequencer then sees the
// divider finish, adds the terms and clamps and commits. The block is back
// in idle in the cycle after the commit. A new request is accepted once the
// block is back in idle, even while the previous result still waits to be
// taken; a result that is not taken holds the next one in its commit step.
// Configuration registers are written through a plain write port; the user
// must write them only while idle, as the block itself does not enforce it.
module peltier_pi_with_direction_relay_core #(
  parameter int unsigned PWM_MAX = 4095
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [pelt_pi_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [pelt_pi_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  pelt_pi_pkg::in_t                      in_data_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output pelt_pi_pkg::out_t                     out_data_o
);
  import pelt_pi_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_SUM  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  localparam logic [PI_W-1:0] PwmMaxW = PI_W'(PWM_MAX);

  // Configuration registers.
  logic [GAIN_W-1:0]        prop_gain_q;
  logic [GAIN_W-1:0]        divisor_q;
  logic signed [SETP_W-1:0] setpoint_q;
  logic [SAMPLE_W-1:0]      ref_temp_q;
  logic [SAMPLE_W-1:0]      deadband_q;

  // Control state.
  logic [1:0]                state_q, state_d;
  logic signed [INTEG_W-1:0] integral_q;
  logic                      relay_q;
  logic                      pending_q;
  logic                      out_valid_q;

  // Datapath registers.
  logic signed [ERR_W-1:0]   err_q;
  logic [HOST_W-1:0]         host_q;
  logic [GAIN_W-1:0]         kp_sh_q;
  logic signed [PROD_W-1:0]  mcand_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [PI_W-1:0]    pi_q;
  out_t                      out_q;

  logic                      in_fire;
  logic                      out_load;
  logic signed [SETP_W-1:0]  temp_w;
  logic signed [ERR_W-1:0]   err_w;
  logic signed [22:0]        temp_x;
  logic signed [22:0]        scaled_w;
  logic [INTEG_W-1:0]        integ_mag;
  logic                      div_done;
  logic [INTEG_W-1:0]        div_quot;
  logic signed [PI_W-1:0]    prod_x;
  logic signed [PI_W-1:0]    quot_x;
  logic signed [PI_W-1:0]    pi_d;
  logic signed [ERR_W-1:0]   setp_x;
  logic signed [ERR_W-1:0]   low_edge;
  logic signed [ERR_W-1:0]   high_edge;
  logic                      cool_w;
  logic                      heat_w;
  logic signed [PI_W-1:0]    sel_w;
  logic [PI_W-1:0]           clamp_w;
  logic signed [INTEG_W:0]   sum_w;
  logic signed [INTEG_W-1:0] sat_w;
  logic                      relay_next;
  logic                      rwrite_w;
  out_t                      res_w;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_load   = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  // Temperature, error and host byte from the incoming samples.
  // The host byte is bits 19..12 of temperature*500 (500 = 512 - 8 - 4).
  always_comb begin
    temp_w   = $signed({1'b0, in_data_i.sample_plus}) -
               $signed({1'b0, in_data_i.sample_minus});
    err_w    = {setpoint_q[SETP_W-1], setpoint_q} - {temp_w[SETP_W-1], temp_w};
    temp_x   = 23'(temp_w);
    scaled_w = (temp_x <<< 9) - (temp_x <<< 3) - (temp_x <<< 2);
  end

  // Magnitude of the integral for the unsigned divider.
  assign integ_mag = integral_q[INTEG_W-1] ? (~integral_q + 1'b1) : integral_q;

  pelt_pi_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_fire),
    .dividend_i (integ_mag),
    .divisor_i  (divisor_q),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  // Proportional plus integral term with the integral's sign restored (proportional alone for a zero divisor).
  always_comb begin
    prod_x = PI_W'(prod_q);
    quot_x = $signed({2'b00, div_quot});
    if (divisor_q == '0) begin
      pi_d = prod_x;
    end else if (integral_q[INTEG_W-1]) begin
      pi_d = prod_x - quot_x;
    end else begin
      pi_d = prod_x + quot_x;
    end
  end

  // Direction decision, clamp, relay write and saturating integral update.
  always_comb begin
    setp_x    = ERR_W'(setpoint_q);
    low_edge  = $signed({2'b00, ref_temp_q}) - $signed({2'b00, deadband_q});
    high_edge = $signed({2'b00, ref_temp_q}) + $signed({2'b00, deadband_q});
    cool_w    = setp_x < low_edge;
    heat_w    = setp_x > high_edge;

    sel_w = cool_w ? -pi_q : pi_q;
    if (sel_w > $signed(PwmMaxW)) begin
      clamp_w = PwmMaxW;
    end else if (sel_w < $signed(PI_W'(1))) begin
      clamp_w = PI_W'(1);
    end else begin
      clamp_w = sel_w;
    end

    priority if (cool_w) begin
      relay_next = 1'b1;
    end else if (heat_w) begin
      relay_next = 1'b0;
    end else begin
      relay_next = relay_q;
    end
    rwrite_w = pending_q || (relay_next != relay_q);

    sum_w = (INTEG_W+1)'(integral_q) + (INTEG_W+1)'(err_q);
    if (sum_w[INTEG_W] != sum_w[INTEG_W-1]) begin
      sat_w = sum_w[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}} : {1'b0, {(INTEG_W-1){1'b1}}};
    end else begin
      sat_w = sum_w[INTEG_W-1:0];
    end

    res_w.pwm_width   = (cool_w || heat_w) ? clamp_w[PWM_W-1:0] : '0;
    res_w.pwm_update  = cool_w || heat_w;
    res_w.relay_on    = relay_next;
    res_w.relay_write = rwrite_w;
    res_w.host_byte   = host_q;
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_fire) state_d = ST_RUN;
      ST_RUN:  if (div_done) state_d = ST_SUM;
      ST_SUM:  state_d = ST_DONE;
      ST_DONE: if (out_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers and configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      integral_q  <= '0;
      relay_q     <= 1'b0;
      pending_q   <= 1'b1;
      out_valid_q <= 1'b0;
      prop_gain_q <= GAIN_W'(125);
      divisor_q   <= GAIN_W'(3500);
      setpoint_q  <= '0;
      ref_temp_q  <= SAMPLE_W'(246);
      deadband_q  <= SAMPLE_W'(17);
    end else begin
      state_q <= state_d;
      if (out_load) begin
        integral_q  <= sat_w;
        relay_q     <= relay_next;
        pending_q   <= 1'b0;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_PROP_GAIN:        prop_gain_q <= cfg_data_i;
          CFG_INTEGRAL_DIVISOR: divisor_q   <= cfg_data_i;
          CFG_SETPOINT:         setpoint_q  <= cfg_data_i[SETP_W-1:0];
          CFG_REF_TEMP:         ref_temp_q  <= cfg_data_i[SAMPLE_W-1:0];
          CFG_DEADBAND:         deadband_q  <= cfg_data_i[SAMPLE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Datapath: capture, shift-add multiply one gain bit per cycle, sum, result.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      err_q   <= err_w;
      host_q  <= scaled_w[19:12];
      kp_sh_q <= prop_gain_q;
      mcand_q <= PROD_W'(err_w);
      prod_q  <= '0;
    end else if (state_q == ST_RUN) begin
      if (kp_sh_q[0]) begin
        prod_q <= prod_q + mcand_q;
      end
      kp_sh_q <= kp_sh_q >> 1;
      mcand_q <= mcand_q <<< 1;
    end
    if (state_q == ST_SUM) begin
      pi_q <= pi_d;
    end
    if (out_load) begin
      out_q <= res_w;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // The divider finishes only while the sequencer waits for it.
  a_div_done_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_RUN))
    else $error("divider finished outside the run phase");

  // A new result appears only after the commit step.
  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_DONE))
    else $error("result raised without a commit");

  // After a commit no relay write is left pending.
  a_pending_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> !pending_q)
    else $error("relay write still pending after commit");

endmodule
